// ===== hdl/wnaf_pkg.sv =====
// Shared types and constants for the width-w NAF scalar recoder.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package wnaf_pkg;

   // Fixed widths of the request fields.
   localparam int WORD_W = 64;
   localparam int IDX_W  = 2;

   // The scalar is always four request words wide; the two-bit index covers exactly those four words.
   localparam int SCALAR_BITS = 256;

   // The word index whose request completes the scalar and starts recoding.
   localparam logic [IDX_W-1:0] IDX_START = 2'd3;

   // Sequencer states of the top level.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // Status that the bit-serial scanner reports for the current position.
   typedef struct packed {
      logic found;   // a nonzero digit starts at the current position
      logic at_end;  // the current position is the last one of the scan
   } scan_status_type;

endpackage

`default_nettype wire

// ===== hdl/wnaf_req_if.sv =====
// Request and response channel interfaces of the NAF recoder.
// Depends on wnaf_pkg for the fixed request field widths.
`default_nettype none

interface wnaf_req_if;
   import wnaf_pkg::*;

   logic                valid;
   logic                ready;
   logic [WORD_W-1:0]   scalar_word;
   logic [IDX_W-1:0]    word_index;

   modport source (output valid, output scalar_word, output word_index, input ready);
   modport sink   (input valid, input scalar_word, input word_index, output ready);
endinterface

interface wnaf_rsp_if #(
   parameter int POS_W  = 9,
   parameter int WINDOW = 5
);
   logic                      valid;
   logic                      ready;
   logic [POS_W-1:0]          digit_position;
   logic signed [WINDOW-1:0]  digit_value;
   logic [POS_W-1:0]          top;
   logic                      empty_res;
   logic                      last;

   modport source (output valid, output digit_position, output digit_value, output top,
                   output empty_res, output last, input ready);
   modport sink   (input valid, input digit_position, input digit_value, input top,
                   input empty_res, input last, output ready);
endinterface

`default_nettype wire

// ===== hdl/wnaf_scalar_recoder_core.sv =====
// Top level of the width-w NAF scalar recoder: word store, sequencer,
// one-digit holding stage and response register. Uses wnaf_pkg, the channel
// interfaces and wnaf_scan.
`default_nettype none

// Channel  | Direction | Carries
// ---------+-----------+-----------------------------------------------------
// req_bus  | in        | scalar_word, word_index (index 3 starts recoding)
// rsp_bus  | out       | digit_position, digit_value, top, empty_res, last
//
// Requests with index 0 to 2 only store their word. A starting request loads
// the scanner, which steps through bit positions 0 to SCALAR_BITS in wnaf_scan,
// one position per step; the sequencer then sends the final response. Reset
// is synchronous and clears the control state only; stored words are
// undefined until written. A found digit waits in a holding stage until the
// next digit or the end of the scan shows whether it is the last; the scan
// holds while that stage cannot move into an occupied response register.

module wnaf_scalar_recoder_core #(
   parameter int WINDOW = 5
) (
   input  wire logic   clock,
   input  wire logic   reset,
   wnaf_req_if.sink    req_bus,
   wnaf_rsp_if.source  rsp_bus
);
   import wnaf_pkg::*;

   localparam int NWORDS      = SCALAR_BITS / WORD_W;
   localparam int STORE_DEPTH = (NWORDS < 3) ? NWORDS : 3;
   localparam int POS_W       = $clog2(SCALAR_BITS + 2);

   state_type                 state_ff, state_in;
   logic                      req_acc;
   logic                      start;
   logic [WORD_W-1:0]         store_ff [STORE_DEPTH];
   logic [SCALAR_BITS-1:0]    load_data;

   scan_status_type           status;
   logic [POS_W-1:0]          scan_pos;
   logic [WINDOW-1:0]         scan_digit;
   logic                      scan_step;

   logic                      pend_valid_ff;
   logic [POS_W-1:0]          pend_pos_ff;
   logic signed [WINDOW-1:0]  pend_digit_ff;

   logic                      out_free;
   logic                      out_load;
   logic                      rsp_valid_ff;
   logic [POS_W-1:0]          out_pos_ff, out_pos_in;
   logic signed [WINDOW-1:0]  out_digit_ff, out_digit_in;
   logic [POS_W-1:0]          out_top_ff, out_top_in;
   logic                      out_empty_ff, out_empty_in;
   logic                      out_last_ff, out_last_in;

   // Request handshake: new words are taken whenever no scalar is in flight.
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_acc       = req_bus.valid && req_bus.ready;
   assign start         = req_acc && (req_bus.word_index == IDX_START);

   // Word store and the parallel load of the scanner; the starting word goes
   // straight into the scanner, words above index 3 cannot be loaded.
   for (genvar k = 0; k < NWORDS; k++) begin : g_word
      if (k < STORE_DEPTH) begin : g_store
         always_ff @(posedge clock) begin
            if (req_acc && (req_bus.word_index == IDX_W'(k))) begin
               store_ff[k] <= req_bus.scalar_word;
            end
         end
         assign load_data[k*WORD_W +: WORD_W] = store_ff[k];
      end else if (k == 3) begin : g_direct
         assign load_data[k*WORD_W +: WORD_W] = req_bus.scalar_word;
      end else begin : g_zero
         assign load_data[k*WORD_W +: WORD_W] = '0;
      end
   end

   wnaf_scan #(
      .WINDOW      (WINDOW),
      .SCALAR_BITS (SCALAR_BITS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .load       (start),
      .load_data  (load_data),
      .step       (scan_step),
      .status     (status),
      .scan_pos   (scan_pos),
      .scan_digit (scan_digit)
   );

   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_step && status.at_end) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs: scan enable and the response to load.
   always_comb begin
      scan_step    = 1'b0;
      out_load     = 1'b0;
      out_pos_in   = pend_pos_ff;
      out_digit_in = pend_digit_ff;
      out_top_in   = '0;
      out_empty_in = 1'b0;
      out_last_in  = 1'b0;
      case (state_ff)
         ST_SCAN: begin
            // A new digit pushes the held one out, which needs a free register.
            scan_step = !(status.found && pend_valid_ff) || out_free;
            out_load  = scan_step && status.found && pend_valid_ff;
         end
         ST_FINISH: begin
            out_load    = out_free;
            out_last_in = 1'b1;
            if (pend_valid_ff) begin
               out_top_in = POS_W'(pend_pos_ff + 1'b1);
            end else begin
               // Zero scalar: a single empty response.
               out_pos_in   = '0;
               out_digit_in = '0;
               out_empty_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Holding stage for the most recent digit.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (start) begin
         pend_valid_ff <= 1'b0;
      end else if (scan_step && status.found) begin
         pend_valid_ff <= 1'b1;
      end else if ((state_ff == ST_FINISH) && out_free) begin
         pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (scan_step && status.found) begin
         pend_pos_ff   <= scan_pos;
         pend_digit_ff <= $signed(scan_digit);
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_pos_ff   <= out_pos_in;
         out_digit_ff <= out_digit_in;
         out_top_ff   <= out_top_in;
         out_empty_ff <= out_empty_in;
         out_last_ff  <= out_last_in;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.digit_position = out_pos_ff;
   assign rsp_bus.digit_value    = out_digit_ff;
   assign rsp_bus.top            = out_top_ff;
   assign rsp_bus.empty_res      = out_empty_ff;
   assign rsp_bus.last           = out_last_ff;

   // A response is never written over one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("response register overwritten while stalled");

   // Every real digit is odd.
   a_odd_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !out_empty_ff |-> out_digit_ff[0])
      else $error("even digit sent");

   // The final digit response carries its own position plus one as top.
   a_top_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_last_ff && !out_empty_ff |->
         out_top_ff == POS_W'(out_pos_ff + 1'b1))
      else $error("top does not follow the last digit");

   // The empty response is final and carries no digit.
   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_empty_ff |->
         out_last_ff && (out_pos_ff == '0) && (out_digit_ff == '0) && (out_top_ff == '0))
      else $error("malformed empty response");

endmodule

`default_nettype wire

// ===== hdl/wnaf_scan.sv =====
// Bit-serial NAF digit scanner: a shift register of the scalar, a carry bit
// and a skip counter. Depends on wnaf_pkg for the status struct.
`default_nettype none

module wnaf_scan #(
   parameter int WINDOW      = 5,
   parameter int SCALAR_BITS = 256
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          load,
   input  wire logic [SCALAR_BITS-1:0]        load_data,
   input  wire logic                          step,
   output wnaf_pkg::scan_status_type          status,
   output logic [$clog2(SCALAR_BITS+2)-1:0]   scan_pos,
   output logic [WINDOW-1:0]                  scan_digit
);
   import wnaf_pkg::*;

   localparam int POS_W  = $clog2(SCALAR_BITS + 2);
   localparam int SKIP_W = $clog2(WINDOW);

   logic [SCALAR_BITS-1:0] bits_ff, bits_in;
   logic                   carry_ff, carry_in;
   logic [SKIP_W-1:0]      skip_ff, skip_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [WINDOW-1:0]      window;
   logic                   cur_bit;

   // The pending carry enters at the current position. When the current bit
   // is set after the carry, the carry only fills bit 0 of the window, so an
   // OR forms the window value without an adder.
   assign cur_bit = bits_ff[0] ^ carry_ff;
   assign window  = bits_ff[WINDOW-1:0] | {{(WINDOW-1){1'b0}}, carry_ff};

   // A window above half range reads as a negative digit in two's complement,
   // which is the window bits themselves; that case leaves a carry upward.
   assign status.found  = (skip_ff == '0) && cur_bit;
   assign status.at_end = (pos_ff == POS_W'(SCALAR_BITS));
   assign scan_pos      = pos_ff;
   assign scan_digit    = window;

   // Next state of the scanner: a parallel load, or a step by one position.
   always_comb begin
      bits_in  = bits_ff;
      carry_in = carry_ff;
      skip_in  = skip_ff;
      pos_in   = pos_ff;
      if (load) begin
         bits_in  = load_data;
         carry_in = 1'b0;
         skip_in  = '0;
         pos_in   = '0;
      end else if (step) begin
         bits_in = {1'b0, bits_ff[SCALAR_BITS-1:1]};
         pos_in  = pos_ff + 1'b1;
         if (skip_ff != '0) begin
            // Positions covered by a digit are zero; the carry waits above them.
            skip_in = skip_ff - 1'b1;
         end else if (cur_bit) begin
            skip_in  = SKIP_W'(WINDOW - 1);
            carry_in = window[WINDOW-1];
         end else begin
            // Bit and carry both set give a zero bit and pass the carry on.
            carry_in = bits_ff[0] & carry_ff;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff <= 1'b0;
         skip_ff  <= '0;
         pos_ff   <= '0;
      end else begin
         carry_ff <= carry_in;
         skip_ff  <= skip_in;
         pos_ff   <= pos_in;
      end
   end

   // Scalar shift register.
   always_ff @(posedge clock) begin
      bits_ff <= bits_in;
   end

   // A digit always leaves a run of zero positions behind it.
   a_no_adjacent: assert property (@(posedge clock) disable iff (reset)
      step && !load && status.found |=> !status.found)
      else $error("two digits found in adjacent positions");

   // A skipped position never changes the pending carry.
   a_skip_carry: assert property (@(posedge clock) disable iff (reset)
      step && !load && (skip_ff != '0) |=> $stable(carry_ff))
      else $error("carry changed inside a digit window");

   // A load restarts the scan at position zero without a carry.
   a_load_clear: assert property (@(posedge clock) disable iff (reset)
      load |=> (pos_ff == '0) && !carry_ff)
      else $error("scan did not restart after load");

endmodule

`default_nettype wire
